// ===== rtl/jpi_pkg.sv =====
// Package for the JSON pretty indenter.
// Holds sizes, character codes, token selects and the controller/datapath structs.
// No dependencies.
`default_nettype none

package jpi_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int DEPTH_W   = 6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam logic TOK_CHAR = 1'b0;
    localparam logic TOK_EOL  = 1'b1;

    localparam logic [1:0] SEL_PRE  = 2'd0;
    localparam logic [1:0] SEL_TAB  = 2'd1;
    localparam logic [1:0] SEL_CHAR = 2'd2;
    localparam logic [1:0] SEL_POST = 2'd3;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic pre_pend;
        logic tabs_zero;
        logic post_pend;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/jpi_ctrl.sv =====
// Controller for the JSON pretty indenter.
// Sequences one word's tokens; depends on jpi_pkg.
`default_nettype none

module jpi_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  jpi_pkg::t_sts i_sts,
    output jpi_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import jpi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEAD = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LEAD;
                end
            end
            S_LEAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    priority if (i_sts.pre_pend) begin
                        o_cmd.sel = SEL_PRE;
                    end else if (!i_sts.tabs_zero) begin
                        o_cmd.sel = SEL_TAB;
                    end else begin
                        o_cmd.sel = SEL_CHAR;
                        n_state   = i_sts.post_pend ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_POST;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jpi_dp.sv =====
// Datapath for the JSON pretty indenter.
// Holds nesting state, the token plan of one word and the output register; uses jpi_pkg.
`default_nettype none

module jpi_dp (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  jpi_pkg::t_cmd i_cmd,
    output jpi_pkg::t_sts o_sts,
    input  wire [7:0]     i_in_char,
    input  wire           i_in_last,
    input  wire           i_out_ready,
    output logic          o_out_valid,
    output logic          o_out_kind,
    output logic [7:0]    o_out_char,
    output logic          o_out_ovf,
    output logic          o_out_last
);
    import jpi_pkg::*;

    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_line_open, n_line_open;
    logic               r_close_wait, n_close_wait;
    logic [DEPTH_W-1:0] r_tabs, n_tabs;
    logic               r_pre, n_pre;
    logic               r_post, n_post;
    logic               r_ovf, n_ovf;
    logic [7:0]         r_char;

    logic               r_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [7:0]         r_out_char, n_out_char;
    logic               r_out_ovf;
    logic               r_out_last, n_out_last;

    logic               is_comma, is_open, is_close;
    logic [DEPTH_W-1:0] depth_dn;
    logic               at_max;

    assign is_comma = (i_in_char == CH_COMMA);
    assign is_open  = (i_in_char == CH_LBRACE) || (i_in_char == CH_LBRACK);
    assign is_close = (i_in_char == CH_RBRACE) || (i_in_char == CH_RBRACK);
    assign at_max   = (r_depth >= DEPTH_W'(MAX_DEPTH));
    assign depth_dn = (r_depth != '0) ? r_depth - DEPTH_W'(1) : '0;

    always_comb begin
        n_depth      = r_depth;
        n_line_open  = r_line_open;
        n_close_wait = r_close_wait;
        n_tabs       = r_tabs;
        n_pre        = r_pre;
        n_post       = r_post;
        n_ovf        = r_ovf;
        if (i_cmd.load) begin
            n_ovf = 1'b0;
            priority if (is_comma) begin
                n_pre  = 1'b0;
                n_post = 1'b1;
                if (r_close_wait) begin
                    n_tabs       = '0;
                    n_close_wait = 1'b0;
                end else begin
                    n_tabs      = r_line_open ? '0 : r_depth;
                    n_line_open = 1'b0;
                end
            end else if (is_open) begin
                n_ovf        = at_max;
                n_pre        = r_close_wait | r_line_open;
                n_tabs       = r_depth;
                n_post       = 1'b1;
                n_depth      = at_max ? r_depth : r_depth + DEPTH_W'(1);
                n_close_wait = 1'b0;
                n_line_open  = 1'b0;
            end else if (is_close) begin
                n_pre        = r_close_wait | r_line_open;
                n_tabs       = depth_dn;
                n_depth      = depth_dn;
                n_post       = i_in_last;
                n_close_wait = 1'b1;
                n_line_open  = 1'b0;
            end else begin
                n_pre        = r_close_wait;
                n_tabs       = r_line_open ? '0 : r_depth;
                n_post       = i_in_last;
                n_line_open  = 1'b1;
                n_close_wait = 1'b0;
            end
            if (i_in_last) begin
                n_depth      = '0;
                n_close_wait = 1'b0;
                n_line_open  = 1'b0;
            end
        end else if (i_cmd.emit) begin
            unique case (i_cmd.sel)
                SEL_PRE:  n_pre  = 1'b0;
                SEL_TAB:  n_tabs = r_tabs - DEPTH_W'(1);
                SEL_CHAR: n_post = r_post;
                SEL_POST: n_post = 1'b0;
                default:  n_post = r_post;
            endcase
        end
    end

    always_comb begin
        n_out_kind = TOK_CHAR;
        n_out_char = '0;
        n_out_last = 1'b0;
        unique case (i_cmd.sel)
            SEL_PRE: begin
                n_out_kind = TOK_EOL;
            end
            SEL_TAB: begin
                n_out_char = CH_TAB;
            end
            SEL_CHAR: begin
                n_out_char = r_char;
                n_out_last = !r_post;
            end
            SEL_POST: begin
                n_out_kind = TOK_EOL;
                n_out_last = 1'b1;
            end
            default: begin
                n_out_kind = TOK_CHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_line_open  <= 1'b0;
            r_close_wait <= 1'b0;
            r_tabs       <= '0;
            r_pre        <= 1'b0;
            r_post       <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_depth      <= n_depth;
            r_line_open  <= n_line_open;
            r_close_wait <= n_close_wait;
            r_tabs       <= n_tabs;
            r_pre        <= n_pre;
            r_post       <= n_post;
            r_ovf        <= n_ovf;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= is_comma ? CH_COMMA : i_in_char;
        end
        if (i_cmd.emit) begin
            r_out_kind <= n_out_kind;
            r_out_char <= n_out_char;
            r_out_ovf  <= r_ovf;
            r_out_last <= n_out_last;
        end
    end

    assign o_sts.pre_pend  = r_pre;
    assign o_sts.tabs_zero = (r_tabs == '0);
    assign o_sts.post_pend = r_post;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_char  = r_out_char;
    assign o_out_ovf   = r_out_ovf;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/json_pretty_indenter_core.sv =====
// Top level of the JSON pretty indenter: controller plus datapath.
// Depends on jpi_pkg, jpi_ctrl and jpi_dp.
//
// Takes compact JSON one byte per input word and emits tab-indented tokens, one token per
// output word: a character (tuser[0] = 0) or a line end (tuser[0] = 1, tdata = 0). tuser[1]
// flags every token of a byte whose opening bracket hit the maximum nesting depth; tlast marks
// a byte's final token. After a byte is accepted, the token sequencer fills the single output
// register one token at a time, and no new byte is accepted until the byte's last token is
// loaded; output backpressure stalls the sequence. A byte with input tlast closes any open
// line and returns the nesting state to zero.
`default_nettype none

module json_pretty_indenter_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [7:0]  i_s_axis_tdata,   // [7:0] in_char
    input  wire        i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic [1:0] o_m_axis_tuser,   // [0] token_kind, [1] depth_overflow
    output logic       o_m_axis_tlast
);
    import jpi_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic out_kind;
    logic out_ovf;

    jpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    jpi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_char   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (out_kind),
        .o_out_char  (o_m_axis_tdata),
        .o_out_ovf   (out_ovf),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {out_ovf, out_kind};

endmodule

`default_nettype wire

// ===== rtl/jpi_chk.sv =====
// Port checker for the JSON pretty indenter, bound to the top level.
// Depends on json_pretty_indenter_core's ports only.
`default_nettype none

module jpi_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_s_axis_tvalid,
    input wire       o_s_axis_tready,
    input wire       o_m_axis_tvalid,
    input wire       i_m_axis_tready,
    input wire [7:0] o_m_axis_tdata,
    input wire [1:0] o_m_axis_tuser,
    input wire       o_m_axis_tlast
);

    a_eol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 8'h00))
        else $error("line end word carries a nonzero character");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
         && $stable(o_m_axis_tlast)))
        else $error("stalled output word changed");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a byte is in progress");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input ready before the byte's tokens are done");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tuser[1] == $past(o_m_axis_tuser[1])))
        else $error("overflow flag changed within one byte's tokens");

endmodule

bind json_pretty_indenter_core jpi_chk u_jpi_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== sim/json_pretty_indenter_core_tb.sv =====
// Self-checking testbench for json_pretty_indenter_core.
// Streams directed and random JSON bytes, predicts the token stream in a local model
// and checks every output word; depends on jpi_pkg and the RTL under rtl/.
`default_nettype none

module json_pretty_indenter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jpi_pkg::*;

    localparam int IDLE_PCT   = 14;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE     = MAX_DEPTH + 8;
    localparam int MAX_REPORTS = 60;

    typedef struct {
        logic       kind;
        logic [7:0] ch;
        logic       ovf;
        logic       last;
    } t_token;

    logic       i_clk;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tready  = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;   // [7:0] out_char
    wire  [1:0] m_tuser;   // [0] token_kind, [1] depth_overflow
    wire        m_tlast;

    t_token             expected_tokens[$];
    t_token             byte_tokens[$];
    logic [DEPTH_W-1:0] model_depth   = '0;
    logic               model_line    = 1'b0;
    logic               model_close   = 1'b0;
    bit                 no_idle       = 1'b0;
    int                 errors        = 0;
    int                 stall_cycles  = 0;

    json_pretty_indenter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic void push_token(logic kind, logic [7:0] ch);
        t_token t;
        t.kind = kind;
        t.ch   = ch;
        t.ovf  = 1'b0;
        t.last = 1'b0;
        byte_tokens = {byte_tokens, t};
    endfunction

    function automatic void push_tabs();
        for (int t = 0; t < int'(model_depth); t++) push_token(TOK_CHAR, CH_TAB);
    endfunction

    function automatic void end_close_line();
        if (model_close) begin
            push_token(TOK_EOL, 8'h00);
            model_close = 1'b0;
        end
    endfunction

    function automatic void end_text_line();
        if (model_line) begin
            push_token(TOK_EOL, 8'h00);
            model_line = 1'b0;
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic l);
        logic ovf;
        ovf = 1'b0;
        byte_tokens.delete();
        if (c == CH_COMMA) begin
            if (model_close) begin
                push_token(TOK_CHAR, CH_COMMA);
                push_token(TOK_EOL, 8'h00);
                model_close = 1'b0;
            end else begin
                if (!model_line) push_tabs();
                push_token(TOK_CHAR, CH_COMMA);
                push_token(TOK_EOL, 8'h00);
                model_line = 1'b0;
            end
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            ovf = (int'(model_depth) >= MAX_DEPTH);
            end_close_line();
            end_text_line();
            push_tabs();
            push_token(TOK_CHAR, c);
            push_token(TOK_EOL, 8'h00);
            if (int'(model_depth) < MAX_DEPTH) model_depth = model_depth + 1'b1;
        end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            end_close_line();
            end_text_line();
            if (model_depth != 0) model_depth = model_depth - 1'b1;
            push_tabs();
            push_token(TOK_CHAR, c);
            model_close = 1'b1;
        end else begin
            end_close_line();
            if (!model_line) begin
                push_tabs();
                model_line = 1'b1;
            end
            push_token(TOK_CHAR, c);
        end
        if (l) begin
            end_close_line();
            end_text_line();
            model_depth = '0;
        end
        foreach (byte_tokens[k]) begin
            byte_tokens[k].ovf  = ovf;
            byte_tokens[k].last = (k == byte_tokens.size() - 1);
            expected_tokens = {expected_tokens, byte_tokens[k]};
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic l);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_tokens(c, l);
    endtask

    task automatic send_text(input string s, input logic l);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], l && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_text("{\"k\":[1,2],", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text("}]]", 1'b0);
        send_text(",,", 1'b0);
        send_byte("x", 1'b1);
        send_text("[]", 1'b1);
        wait_drained();
    endtask

    task automatic test_depth_overflow();
        repeat (MAX_DEPTH + 2) send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_COMMA, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_docs(input int n_items);
        int sent;
        int lvl;
        int doc_len;
        int r;
        sent    = 0;
        lvl     = 0;
        doc_len = $urandom_range(30, 5);
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (doc_len == 0) begin
                while (lvl > 1) begin
                    send_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK, 1'b0);
                    lvl--;
                    sent++;
                end
                if (lvl == 1) send_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK, 1'b1);
                else send_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b1);
                sent++;
                lvl     = 0;
                doc_len = $urandom_range(30, 5);
            end else if (r < 22 && lvl < 8) begin
                send_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK, 1'b0);
                lvl++;
                sent++;
                doc_len--;
            end else if (r < 40 && lvl > 0) begin
                send_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK, 1'b0);
                lvl--;
                sent++;
                doc_len--;
            end else if (r < 75) begin
                repeat ($urandom_range(3, 1)) begin
                    send_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
                    sent++;
                end
                doc_len--;
            end else if (r < 92) begin
                send_byte(CH_COMMA, 1'b0);
                sent++;
                doc_len--;
            end else begin
                send_byte(8'($urandom_range(255)), ($urandom_range(99) < 5));
                sent++;
                doc_len--;
            end
        end
        while (lvl > 0) begin
            send_byte(CH_RBRACK, lvl == 1);
            lvl--;
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_random_docs(n_items);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_noise(input int n_items);
        logic [7:0] c;
        repeat (n_items) begin
            case ($urandom_range(7))
                0: c = CH_COMMA;
                1: c = $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
                2: c = $urandom_range(1) ? CH_RBRACE : CH_RBRACK;
                default: c = 8'($urandom_range(255));
            endcase
            send_byte(c, ($urandom_range(99) < 10));
        end
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_token want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word: expected none, actual data %02h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", {7'd0, want.kind}, {7'd0, m_tuser[0]});
                check_field("out_char", want.ch, m_tdata);
                check_field("depth_overflow", {7'd0, want.ovf}, {7'd0, m_tuser[1]});
                check_field("tlast", {7'd0, want.last}, {7'd0, m_tlast});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("json_pretty_indenter_core regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_depth_overflow();
        test_random_docs(60);
        wait_drained();
        test_back_to_back(50);
        test_random_noise(40);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("json_pretty_indenter_core regression: pass");
        end else begin
            $display("json_pretty_indenter_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
